>>> rtl/bbc_pkg.sv
// Package for the block buffer cache: constants, command and result codes, beat types.
package bbc_pkg;

   localparam int NumSlotsDefault   = 32;
   localparam int DeviceBitsDefault = 8;
   localparam int RefBitsDefault    = 8;

   localparam logic [2:0] CmdGet        = 3'd0;
   localparam logic [2:0] CmdRelease    = 3'd1;
   localparam logic [2:0] CmdWriteRel   = 3'd2;
   localparam logic [2:0] CmdMarkDirty  = 3'd3;
   localparam logic [2:0] CmdSync       = 3'd4;

   localparam logic [2:0] KindHit       = 3'd0;
   localparam logic [2:0] KindRead      = 3'd1;
   localparam logic [2:0] KindWriteback = 3'd2;
   localparam logic [2:0] KindNoFree    = 3'd3;
   localparam logic [2:0] KindDone      = 3'd4;
   localparam logic [2:0] KindError     = 3'd5;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  device_id;
      logic [31:0] sector_number;
      logic [4:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  slot_out;
      logic [7:0]  device_out;
      logic [31:0] sector_out;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      StIdle,
      StScan,
      StDecide,
      StEvictWb,
      StFill,
      StSlot,
      StSyncScan,
      StSyncDone,
      StFront,
      StDone
   } state_type;

endpackage

>>> rtl/block_buffer_cache_lru.sv
// Top level of the block buffer cache: slot state in registers, one scan sequencer.
// A get scans every slot once; release, write-release and mark dirty act on one slot, and a
// last release also sweeps the ranks; sync checks one rank-slot pair a cycle over every pair.
// Throughput: one command at a time; busy stays high until the last beat is out.
// Reset: synchronous; all slots clear and untagged, slot i holds rank i, no beat pending.
// Results are strobed for one cycle each; the receiver cannot stall them.
module block_buffer_cache_lru #(
   parameter int NUM_SLOTS   = bbc_pkg::NumSlotsDefault,
   parameter int DEVICE_BITS = bbc_pkg::DeviceBitsDefault,
   parameter int REF_BITS    = bbc_pkg::RefBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bbc_pkg::req_type req_data,
   output logic             rsp_valid,
   output bbc_pkg::rsp_type rsp_data
);

   localparam int IdxBits = $clog2(NUM_SLOTS);
   localparam int CntBits = $clog2(NUM_SLOTS + 1);
   localparam logic [REF_BITS-1:0] RefMax = {REF_BITS{1'b1}};

   logic [DEVICE_BITS-1:0] tag_dev_ff [NUM_SLOTS];
   logic [31:0]            tag_sec_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]   tagged_ff, dirty_ff;
   logic [REF_BITS-1:0]    ref_ff [NUM_SLOTS];
   logic [IdxBits-1:0]     rank_ff [NUM_SLOTS];

   bbc_pkg::state_type state_ff, state_in;
   bbc_pkg::req_type   req_ff;
   logic [CntBits-1:0] idx_ff, idx_in;
   logic [CntBits-1:0] rk_ff, rk_in;
   logic               hit_ff, hit_in, found_ff, found_in;
   logic [IdxBits-1:0] sel_ff, sel_in;
   logic [IdxBits-1:0] best_ff, best_in;
   logic [IdxBits-1:0] front_rank_ff;
   logic               rsp_valid_ff;
   bbc_pkg::rsp_type   rsp_ff, rsp_in;
   logic               emit;

   logic [IdxBits-1:0]     ci;
   logic [IdxBits-1:0]     rs;
   logic [DEVICE_BITS-1:0] req_dev;
   logic [7:0]             dev8_ci, dev8_sel, dev8_rs, dev8_req;

   // Shared compare unit: one slot a cycle under the scan index.
   assign ci      = idx_ff[IdxBits-1:0];
   assign rs      = IdxBits'(req_ff.slot_index);
   assign req_dev = DEVICE_BITS'(req_ff.device_id);
   assign dev8_ci  = 8'(tag_dev_ff[ci]);
   assign dev8_sel = 8'(tag_dev_ff[sel_ff]);
   assign dev8_rs  = 8'(tag_dev_ff[rs]);
   assign dev8_req = 8'(req_dev);

   assign busy      = (state_ff != bbc_pkg::StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // State register and request capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbc_pkg::StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
      end
      if (start && !busy) req_ff <= req_data;
      idx_ff   <= idx_in;
      rk_ff    <= rk_in;
      hit_ff   <= hit_in;
      found_ff <= found_in;
      sel_ff   <= sel_in;
      best_ff  <= best_in;
      rsp_ff   <= rsp_in;
   end

   // Sequencer: next state and the beat to present.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rk_in    = rk_ff;
      hit_in   = hit_ff;
      found_in = found_ff;
      sel_in   = sel_ff;
      best_in  = best_ff;
      rsp_in   = rsp_ff;
      emit     = 1'b0;
      unique case (state_ff)
         bbc_pkg::StIdle: begin
            if (start) begin
               idx_in   = '0;
               rk_in    = '0;
               hit_in   = 1'b0;
               found_in = 1'b0;
               unique case (req_data.cmd)
                  bbc_pkg::CmdGet:  state_in = bbc_pkg::StScan;
                  bbc_pkg::CmdSync: state_in = bbc_pkg::StSyncScan;
                  default:          state_in = bbc_pkg::StSlot;
               endcase
            end
         end
         bbc_pkg::StScan: begin
            if (!hit_ff && tagged_ff[ci] && tag_dev_ff[ci] == req_dev &&
                tag_sec_ff[ci] == req_ff.sector_number) begin
               hit_in = 1'b1;
               sel_in = ci;
            end
            if (ref_ff[ci] == '0 && (!found_ff || rank_ff[ci] > best_ff)) begin
               found_in = 1'b1;
               best_in  = rank_ff[ci];
               if (!hit_ff) sel_in = hit_in ? ci : ci;
            end
            if (hit_in && !hit_ff) sel_in = ci;
            else if (hit_ff) sel_in = sel_ff;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CntBits'(NUM_SLOTS - 1)) state_in = bbc_pkg::StDecide;
         end
         bbc_pkg::StDecide: begin
            emit   = 1'b1;
            rsp_in = '{bbc_pkg::KindHit, 5'(sel_ff), dev8_req,
                       req_ff.sector_number, 1'b1};
            state_in = bbc_pkg::StDone;
            if (hit_ff) begin
               if (ref_ff[sel_ff] == RefMax) rsp_in.kind = bbc_pkg::KindError;
            end else if (!found_ff) begin
               rsp_in.kind     = bbc_pkg::KindNoFree;
               rsp_in.slot_out = '0;
            end else if (dirty_ff[sel_ff]) begin
               rsp_in   = '{bbc_pkg::KindWriteback, 5'(sel_ff), dev8_sel,
                            tag_sec_ff[sel_ff], 1'b0};
               state_in = bbc_pkg::StFill;
            end else begin
               rsp_in.kind = bbc_pkg::KindRead;
            end
         end
         bbc_pkg::StFill: begin
            emit     = 1'b1;
            rsp_in   = '{bbc_pkg::KindRead, 5'(sel_ff), dev8_req,
                         req_ff.sector_number, 1'b1};
            state_in = bbc_pkg::StDone;
         end
         bbc_pkg::StEvictWb: state_in = bbc_pkg::StDone;
         bbc_pkg::StSlot: begin
            emit     = 1'b1;
            state_in = bbc_pkg::StDone;
            if (req_ff.cmd > bbc_pkg::CmdSync) begin
               rsp_in = '{bbc_pkg::KindError, 5'd0, 8'd0, 32'd0, 1'b1};
            end else if (32'(req_ff.slot_index) >= 32'(NUM_SLOTS)) begin
               rsp_in = '{bbc_pkg::KindError, req_ff.slot_index, 8'd0, 32'd0, 1'b1};
            end else begin
               rsp_in = '{bbc_pkg::KindDone, req_ff.slot_index, dev8_rs,
                          tag_sec_ff[rs], 1'b1};
               if (ref_ff[rs] == '0) begin
                  rsp_in.kind = bbc_pkg::KindError;
               end else if (req_ff.cmd == bbc_pkg::CmdWriteRel) begin
                  rsp_in.kind = bbc_pkg::KindWriteback;
                  rsp_in.last = 1'b0;
                  state_in    = bbc_pkg::StSyncDone;
               end else if (req_ff.cmd != bbc_pkg::CmdMarkDirty &&
                            ref_ff[rs] == REF_BITS'(1)) begin
                  // The release beat follows the rank sweep.
                  emit     = 1'b0;
                  idx_in   = '0;
                  state_in = bbc_pkg::StFront;
               end
            end
         end
         bbc_pkg::StSyncScan: begin
            if (rank_ff[ci] == rk_ff[IdxBits-1:0] && ref_ff[ci] == '0 && dirty_ff[ci]) begin
               emit   = 1'b1;
               rsp_in = '{bbc_pkg::KindWriteback, 5'(ci), dev8_ci, tag_sec_ff[ci], 1'b0};
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CntBits'(NUM_SLOTS - 1)) begin
               idx_in = '0;
               rk_in  = rk_ff + 1'b1;
               if (rk_ff == CntBits'(NUM_SLOTS - 1)) state_in = bbc_pkg::StSyncDone;
            end
         end
         bbc_pkg::StSyncDone: begin
            // Closing beat of sync, or the release beat after a write-release writeback.
            emit     = 1'b1;
            state_in = bbc_pkg::StDone;
            if (req_ff.cmd == bbc_pkg::CmdSync) begin
               rsp_in = '{bbc_pkg::KindDone, 5'd0, 8'd0, 32'd0, 1'b1};
            end else begin
               rsp_in = '{bbc_pkg::KindDone, req_ff.slot_index, dev8_rs,
                          tag_sec_ff[rs], 1'b1};
               if (ref_ff[rs] == REF_BITS'(1)) begin
                  emit     = 1'b0;
                  idx_in   = '0;
                  state_in = bbc_pkg::StFront;
               end
            end
         end
         bbc_pkg::StFront: begin
            // Sweep that moves the released slot to rank zero, one slot a cycle.
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CntBits'(NUM_SLOTS - 1)) begin
               emit     = 1'b1;
               rsp_in   = '{bbc_pkg::KindDone, req_ff.slot_index, dev8_rs,
                            tag_sec_ff[rs], 1'b1};
               state_in = bbc_pkg::StDone;
            end
         end
         bbc_pkg::StDone: state_in = bbc_pkg::StIdle;
         default:         state_in = bbc_pkg::StIdle;
      endcase
   end

   // Slot state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         tagged_ff <= '0;
         dirty_ff  <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            ref_ff[i]     <= '0;
            rank_ff[i]    <= IdxBits'(i);
            tag_dev_ff[i] <= '0;
            tag_sec_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            bbc_pkg::StDecide: begin
               if (hit_ff) begin
                  if (ref_ff[sel_ff] != RefMax) ref_ff[sel_ff] <= ref_ff[sel_ff] + 1'b1;
               end else if (found_ff) begin
                  dirty_ff[sel_ff]   <= 1'b0;
                  tagged_ff[sel_ff]  <= 1'b1;
                  tag_dev_ff[sel_ff] <= req_dev;
                  tag_sec_ff[sel_ff] <= req_ff.sector_number;
                  ref_ff[sel_ff]     <= REF_BITS'(1);
               end
            end
            bbc_pkg::StSlot: begin
               if (req_ff.cmd <= bbc_pkg::CmdSync &&
                   32'(req_ff.slot_index) < 32'(NUM_SLOTS) && ref_ff[rs] != '0) begin
                  if (req_ff.cmd == bbc_pkg::CmdMarkDirty) dirty_ff[rs] <= 1'b1;
                  else if (req_ff.cmd == bbc_pkg::CmdWriteRel) dirty_ff[rs] <= 1'b0;
                  else ref_ff[rs] <= ref_ff[rs] - 1'b1;
                  front_rank_ff <= rank_ff[rs];
               end
            end
            bbc_pkg::StSyncDone: begin
               if (req_ff.cmd != bbc_pkg::CmdSync) ref_ff[rs] <= ref_ff[rs] - 1'b1;
            end
            bbc_pkg::StSyncScan: begin
               if (rank_ff[ci] == rk_ff[IdxBits-1:0] && ref_ff[ci] == '0)
                  dirty_ff[ci] <= 1'b0;
            end
            bbc_pkg::StFront: begin
               if (ci == rs) rank_ff[ci] <= '0;
               else if (rank_ff[ci] < front_rank_ff) rank_ff[ci] <= rank_ff[ci] + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Checks on the sequencer.
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("beat out while idle");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !rsp_valid) else $error("beat after last");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bbc_pkg::StIdle) |=> !rsp_valid) else $error("beat from idle");

endmodule

>>> tb/sv/block_buffer_cache_lru_tb.sv
// Self-checking testbench for the block buffer cache: tag lookup, reference counts and eviction.
module block_buffer_cache_lru_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Slots = 32;
   localparam int RefMax = 255;
   localparam int StallLimit = 20000;
   localparam int TailCycles = 1100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   bbc_pkg::req_type req_data = '0;
   logic rsp_valid;
   bbc_pkg::rsp_type rsp_data;

   block_buffer_cache_lru dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // Shadow copy of the slot state.
   logic [7:0]  shadow_dev [Slots];
   logic [31:0] shadow_sec [Slots];
   logic        shadow_tagged [Slots];
   logic        shadow_dirty [Slots];
   int          shadow_refs [Slots];
   int          shadow_rank [Slots];

   bbc_pkg::rsp_type pending_rsp [$];
   int errors = 0;
   int beats_in = 0;
   int beats_out = 0;
   int idle_cycles = 0;
   int gap_pct = 0;
   logic [7:0]  used_dev [$];
   logic [31:0] used_sec [$];

   function automatic bbc_pkg::rsp_type mk(logic [2:0] k, int s, logic [7:0] d,
                                           logic [31:0] q, logic l);
      bbc_pkg::rsp_type r;
      r.kind = k; r.slot_out = s[4:0]; r.device_out = d; r.sector_out = q; r.last = l;
      return r;
   endfunction

   task automatic shadow_reset();
      for (int i = 0; i < Slots; i++) begin
         shadow_dev[i] = '0; shadow_sec[i] = '0; shadow_tagged[i] = 1'b0;
         shadow_dirty[i] = 1'b0; shadow_refs[i] = 0; shadow_rank[i] = i;
      end
   endtask

   // Works out the result beats one command causes and advances the shadow state.
   task automatic predict_cache(bbc_pkg::req_type r);
      int s;
      int v;
      int best;
      bit found;
      s = r.slot_index;
      if (r.cmd == bbc_pkg::CmdGet) begin
         for (int i = 0; i < Slots; i++) begin
            if (shadow_tagged[i] && shadow_dev[i] == r.device_id &&
                shadow_sec[i] == r.sector_number) begin
               if (shadow_refs[i] >= RefMax) begin
                  pending_rsp.push_back(mk(bbc_pkg::KindError, i, r.device_id,
                                           r.sector_number, 1));
               end else begin
                  shadow_refs[i]++;
                  pending_rsp.push_back(mk(bbc_pkg::KindHit, i, r.device_id,
                                           r.sector_number, 1));
               end
               return;
            end
         end
         found = 0; v = 0; best = 0;
         for (int i = 0; i < Slots; i++) begin
            if (shadow_refs[i] == 0 && (!found || shadow_rank[i] > best)) begin
               found = 1; v = i; best = shadow_rank[i];
            end
         end
         if (!found) begin
            pending_rsp.push_back(mk(bbc_pkg::KindNoFree, 0, r.device_id, r.sector_number, 1));
            return;
         end
         if (shadow_dirty[v])
            pending_rsp.push_back(mk(bbc_pkg::KindWriteback, v, shadow_dev[v],
                                     shadow_sec[v], 0));
         shadow_dirty[v] = 0; shadow_dev[v] = r.device_id; shadow_sec[v] = r.sector_number;
         shadow_tagged[v] = 1; shadow_refs[v] = 1;
         pending_rsp.push_back(mk(bbc_pkg::KindRead, v, r.device_id, r.sector_number, 1));
         return;
      end
      if (r.cmd == bbc_pkg::CmdSync) begin
         for (int k = 0; k < Slots; k++)
            for (int i = 0; i < Slots; i++)
               if (shadow_rank[i] == k && shadow_refs[i] == 0 && shadow_dirty[i]) begin
                  pending_rsp.push_back(mk(bbc_pkg::KindWriteback, i, shadow_dev[i],
                                           shadow_sec[i], 0));
                  shadow_dirty[i] = 0;
               end
         pending_rsp.push_back(mk(bbc_pkg::KindDone, 0, '0, '0, 1));
         return;
      end
      if (r.cmd > bbc_pkg::CmdSync) begin
         pending_rsp.push_back(mk(bbc_pkg::KindError, 0, '0, '0, 1));
         return;
      end
      if (shadow_refs[s] == 0) begin
         pending_rsp.push_back(mk(bbc_pkg::KindError, s, shadow_dev[s], shadow_sec[s], 1));
         return;
      end
      if (r.cmd == bbc_pkg::CmdMarkDirty) begin
         shadow_dirty[s] = 1;
         pending_rsp.push_back(mk(bbc_pkg::KindDone, s, shadow_dev[s], shadow_sec[s], 1));
         return;
      end
      if (r.cmd == bbc_pkg::CmdWriteRel) begin
         pending_rsp.push_back(mk(bbc_pkg::KindWriteback, s, shadow_dev[s], shadow_sec[s], 0));
         shadow_dirty[s] = 0;
      end
      shadow_refs[s]--;
      if (shadow_refs[s] == 0) begin
         for (int j = 0; j < Slots; j++)
            if (shadow_rank[j] < shadow_rank[s]) shadow_rank[j]++;
         shadow_rank[s] = 0;
      end
      pending_rsp.push_back(mk(bbc_pkg::KindDone, s, shadow_dev[s], shadow_sec[s], 1));
   endtask

   task automatic report_mismatch(string what, bbc_pkg::rsp_type got,
                                  bbc_pkg::rsp_type want);
      errors++;
      $display("MISMATCH %s: got k%0d s%0d d%0h q%0h l%0b, want k%0d s%0d d%0h q%0h l%0b",
               what, got.kind, got.slot_out, got.device_out, got.sector_out, got.last,
               want.kind, want.slot_out, want.device_out, want.sector_out, want.last);
   endtask

   // Sends one command beat at the falling edge and waits for it to be taken.
   task automatic send_cmd(logic [2:0] c, logic [7:0] d, logic [31:0] q, logic [4:0] s);
      bbc_pkg::req_type r;
      r.cmd = c; r.device_id = d; r.sector_number = q; r.slot_index = s;
      while (gap_pct > 0 && $urandom_range(99) < gap_pct) @(negedge clock);
      req_data <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_cache(r);
      beats_in++;
      @(negedge clock);
      start <= 1'b0;
      // Wait for the command to finish before offering another.
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Checks each result beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected beat", rsp_data, '0);
         end else begin
            bbc_pkg::rsp_type want;
            want = pending_rsp.pop_front();
            beats_out++;
            if (rsp_data.kind != want.kind) report_mismatch("kind", rsp_data, want);
            else if (rsp_data.slot_out != want.slot_out) report_mismatch("slot", rsp_data, want);
            else if (rsp_data.device_out != want.device_out)
               report_mismatch("device", rsp_data, want);
            else if (rsp_data.sector_out != want.sector_out)
               report_mismatch("sector", rsp_data, want);
            else if (rsp_data.last != want.last) report_mismatch("last", rsp_data, want);
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("[block_buffer_cache_lru] ERROR");
         $finish;
      end
   end

   function automatic int held_slot();
      int c [$];
      for (int i = 0; i < Slots; i++) if (shadow_refs[i] > 0) c.push_back(i);
      if (c.size() == 0) return $urandom_range(Slots - 1);
      return c[$urandom_range(c.size() - 1)];
   endfunction

   task automatic test_directed();
      send_cmd(bbc_pkg::CmdRelease, 8'h00, 32'h0, 5'd0);        // release of unheld slot
      send_cmd(bbc_pkg::CmdMarkDirty, 8'h00, 32'h0, 5'd31);     // mark dirty of unheld slot
      send_cmd(bbc_pkg::CmdGet, 8'hFF, 32'hFFFF_FFFF, 5'd31);
      send_cmd(bbc_pkg::CmdGet, 8'h00, 32'h0, 5'd0);
      send_cmd(bbc_pkg::CmdGet, 8'hFF, 32'hFFFF_FFFF, 5'd0);    // hit
      send_cmd(bbc_pkg::CmdMarkDirty, 8'h00, 32'h0, 5'd31);
      send_cmd(bbc_pkg::CmdWriteRel, 8'h00, 32'h0, 5'd31);
      send_cmd(bbc_pkg::CmdWriteRel, 8'h00, 32'h0, 5'd31);
      send_cmd(bbc_pkg::CmdMarkDirty, 8'h00, 32'h0, 5'd30);
      send_cmd(bbc_pkg::CmdRelease, 8'h00, 32'h0, 5'd30);
      send_cmd(bbc_pkg::CmdSync, 8'hA5, 32'h1234_5678, 5'd7);
      send_cmd(3'd5, 8'h00, 32'h0, 5'd0);                       // unknown commands
      send_cmd(3'd6, 8'h00, 32'h0, 5'd0);
      send_cmd(3'd7, 8'hFF, 32'hFFFF_FFFF, 5'd31);
      send_cmd(bbc_pkg::CmdWriteRel, 8'h00, 32'h0, 5'd30);      // write-release unheld
      send_cmd(bbc_pkg::CmdSync, 8'h00, 32'h0, 5'd0);
   endtask

   // Fills every slot so that a miss finds no free slot, then frees them, every third one dirty.
   task automatic test_no_free_slot();
      for (int i = 0; i < Slots; i++) send_cmd(bbc_pkg::CmdGet, 8'h40, i, 5'd0);
      send_cmd(bbc_pkg::CmdGet, 8'h41, 32'hDEAD_BEEF, 5'd0);
      for (int i = 0; i < Slots; i += 3) send_cmd(bbc_pkg::CmdMarkDirty, 8'h00, 32'h0, 5'(i));
      for (int i = 0; i < Slots; i++) send_cmd(bbc_pkg::CmdRelease, 8'h00, 32'h0, 5'(i));
      send_cmd(bbc_pkg::CmdGet, 8'h77, 32'h77, 5'd0);           // evicts a dirty slot
      send_cmd(bbc_pkg::CmdSync, 8'h00, 32'h0, 5'd0);
   endtask

   // Drives one slot's reference count to its ceiling; the slot stays held.
   task automatic test_ref_overflow();
      for (int i = 0; i < RefMax + 1; i++)
         send_cmd(bbc_pkg::CmdGet, 8'h5A, 32'h0F0F_0F0F, 5'd0);
   endtask

   task automatic test_random(int n);
      logic [2:0] c;
      int pick;
      int s;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            c = bbc_pkg::CmdGet;
         end else if (pick < 65) c = bbc_pkg::CmdRelease;
         else if (pick < 78) c = bbc_pkg::CmdWriteRel;
         else if (pick < 90) c = bbc_pkg::CmdMarkDirty;
         else if (pick < 95) c = bbc_pkg::CmdSync;
         else c = 3'($urandom_range(7));
         s = ($urandom_range(9) == 0) ? $urandom_range(Slots - 1) : held_slot();
         if (c == bbc_pkg::CmdGet && used_dev.size() > 0 && $urandom_range(1)) begin
            pick = $urandom_range(used_dev.size() - 1);
            send_cmd(c, used_dev[pick], used_sec[pick], 5'(s));
         end else begin
            logic [7:0] d;
            logic [31:0] q;
            d = 8'($urandom); q = $urandom;
            if (c == bbc_pkg::CmdGet) begin used_dev.push_back(d); used_sec.push_back(q); end
            send_cmd(c, d, q, 5'(s));
         end
      end
   endtask

   initial begin
      shadow_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      gap_pct = 0;
      test_directed();
      test_no_free_slot();
      test_ref_overflow();
      gap_pct = 0;  test_random(15);
      gap_pct = 87; test_random(15);
      gap_pct = 0;  test_random(15);
      gap_pct = 11; test_random(15);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      $display("Covered %0d command beats and %0d result beats: hits, fills, evictions,",
               beats_in, beats_out);
      $display("writebacks, sync, no-free-slot, reference overflow and error cases.");
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("[block_buffer_cache_lru] OK");
      end else begin
         $display("[block_buffer_cache_lru] ERROR");
      end
      $finish;
   end
endmodule
